[hdl/tthc_pkg.sv]
// Package: shared constants, types, ROM builder and digit split for the thermostat.
package tthc_pkg;

	localparam int SAMPLES_PER_READING = 13;

	localparam int OPCODE_W = 2;
	localparam int SAMPLE_W = 10;
	localparam int TEMP_W   = 7;
	localparam int DIGIT_W  = 4;
	localparam int SUM_W    = 16;
	localparam int COUNT_W  = $clog2(SAMPLES_PER_READING + 1);
	localparam int ROM_AW   = 10;
	localparam int ROM_DEPTH = 1 << ROM_AW;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;
	localparam int REG_SEL_BIT = 2;

	localparam logic [TEMP_W-1:0] TEMP_MAX        = 7'd99;
	localparam logic [TEMP_W-1:0] SET_POINT_RESET = 7'd50;
	localparam logic [TEMP_W-1:0] LOW_RESET       = 7'd40;
	localparam logic [TEMP_W-1:0] HIGH_RESET      = 7'd80;

	// floor(x / SAMPLES_PER_READING) as (x * RECIP) >> RECIP_SHIFT, exact for 16-bit x
	localparam int RECIP_SHIFT = 24;
	localparam int RECIP_W     = RECIP_SHIFT + 1;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << RECIP_SHIFT) + SAMPLES_PER_READING - 1) / SAMPLES_PER_READING);

	typedef enum logic [OPCODE_W-1:0] {
		OP_RAISE  = 2'd0,
		OP_LOWER  = 2'd1,
		OP_SAMPLE = 2'd2
	} tthc_op_t;

	typedef enum logic {
		REG_LOW  = 1'b0,
		REG_HIGH = 1'b1
	} tthc_reg_t;

	typedef struct packed {
		logic [TEMP_W-1:0] low;
		logic [TEMP_W-1:0] high;
	} tthc_limits_t;

	typedef struct packed {
		logic [DIGIT_W-1:0] tens;
		logic [DIGIT_W-1:0] ones;
	} tthc_digits_t;

	typedef logic [TEMP_W-1:0] tthc_rom_t [ROM_DEPTH];

	// tens = (v * 205) >> 11 is exact for v < 1029
	function automatic tthc_digits_t split_digits(input logic [TEMP_W-1:0] v);
		logic [14:0]        prod;
		logic [DIGIT_W-1:0] tens;
		logic [TEMP_W-1:0]  rest;
		tthc_digits_t       d;
		prod   = 15'(v) * 15'd205;
		tens   = prod[14:11];
		rest   = v - TEMP_W'(tens) * 7'd10;
		d.tens = tens;
		d.ones = rest[DIGIT_W-1:0];
		return d;
	endfunction

	// ---- elaboration-time ROM contents: Steinhart-Hart in Q48 fixed point ----
	localparam int          FRAC       = 48;
	localparam logic [63:0] ONE_Q      = 64'd1 << FRAC;
	localparam logic [63:0] ONE_THIRD  = (64'd1 << FRAC) / 3;
	localparam logic [63:0] TARGET_Q12 = 64'd4096000000000000000;

	function automatic logic [63:0] mul_shift(input logic [63:0] a, input logic [63:0] b,
		input int s);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		p = p >> s;
		return p[63:0];
	endfunction

	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] r;
		logic [63:0] q;
		r = '0;
		q = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[63:0], num[i]};
			if (r >= {1'b0, den}) begin
				r    = r - {1'b0, den};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [63:0] frac_div(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] r;
		logic [63:0] q;
		r = num;
		q = '0;
		for (int i = 0; i < FRAC; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q = q | 64'd1;
			end
		end
		return q;
	endfunction

	function automatic logic [63:0] twice_atanh(input logic [63:0] z);
		logic [63:0] z2;
		logic [63:0] term;
		logic [63:0] sum;
		z2   = mul_shift(z, z, FRAC);
		term = z;
		sum  = '0;
		for (int k = 1; k <= 41; k += 2) begin
			sum  = sum + udiv64(term, 64'(k));
			term = mul_shift(term, z2, FRAC);
		end
		return sum << 1;
	endfunction

	function automatic logic [63:0] ln_q48(input logic [63:0] r, input logic [63:0] ln2);
		int          e;
		logic [63:0] m;
		e = 0;
		for (int i = 0; i < 40; i++) begin
			if ((r >> (i + 1)) != 64'd0) e = i + 1;
		end
		m = r << (FRAC - e);
		return 64'(e) * ln2 + twice_atanh(frac_div(m - ONE_Q, m + ONE_Q));
	endfunction

	function automatic logic [TEMP_W-1:0] rom_entry(input logic [63:0] v,
		input logic [63:0] ln2);
		logic signed [63:0] r;
		logic [63:0]        l;
		logic [63:0]        l3;
		logic [63:0]        n;
		logic [63:0]        prod;
		logic [TEMP_W-1:0]  deg;
		logic               go;
		if (v == 64'd0) return '0;
		r = $signed(udiv64(64'd10230000, v)) - 64'sd10000;
		if (r <= 64'sd0) return TEMP_MAX;
		l   = ln_q48(64'(r), ln2);
		l3  = mul_shift(mul_shift(l, l, FRAC), l, FRAC);
		n   = (64'd11291480000 << 12) + mul_shift(l, 64'd2341250000, 36)
			+ mul_shift(l3, 64'd876741, 36);
		deg = '0;
		go  = 1'b1;
		for (int k = 1; k <= 99; k++) begin
			prod = n * (64'd27315 + 64'd100 * 64'(k));
			if (go && prod <= TARGET_Q12) deg = TEMP_W'(k);
			else go = 1'b0;
		end
		return deg;
	endfunction

	function automatic tthc_rom_t build_rom();
		tthc_rom_t   rom;
		logic [63:0] ln2;
		ln2 = twice_atanh(ONE_THIRD);
		for (int v = 0; v < ROM_DEPTH; v++) begin
			rom[v] = rom_entry(64'(v), ln2);
		end
		return rom;
	endfunction

endpackage

[hdl/tthc_ifs.sv]
// Interfaces: command item channel and display item channel.
interface tthc_cmd_if import tthc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [SAMPLE_W-1:0] sample;

	modport source (output valid, opcode, sample, input ready);
	modport sink   (input valid, opcode, sample, output ready);
endinterface

interface tthc_disp_if import tthc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               heater_on;
	logic [TEMP_W-1:0]  set_point_now;
	logic [DIGIT_W-1:0] set_tens;
	logic [DIGIT_W-1:0] set_ones;
	logic [TEMP_W-1:0]  measured_now;
	logic [DIGIT_W-1:0] measured_tens;
	logic [DIGIT_W-1:0] measured_ones;
	logic               reading_done;

	modport source (output valid, heater_on, set_point_now, set_tens, set_ones,
		measured_now, measured_tens, measured_ones, reading_done, input ready);
	modport sink   (input valid, heater_on, set_point_now, set_tens, set_ones,
		measured_now, measured_tens, measured_ones, reading_done, output ready);
endinterface

[hdl/tthc_regs.sv]
// APB register file holding the set point limits.
module tthc_regs import tthc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output tthc_limits_t       limits
);

	logic [TEMP_W-1:0] low_q;
	logic [TEMP_W-1:0] high_q;
	tthc_reg_t         sel;

	assign sel    = tthc_reg_t'(paddr[REG_SEL_BIT]);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= LOW_RESET;
			high_q <= HIGH_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (sel)
				REG_LOW:  low_q  <= pwdata[TEMP_W-1:0];
				REG_HIGH: high_q <= pwdata[TEMP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (sel)
			REG_LOW:  prdata = PDATA_W'(low_q);
			REG_HIGH: prdata = PDATA_W'(high_q);
			default:  prdata = '0;
		endcase
	end

	// limits above the display range act as 99
	assign limits.low  = (low_q  > TEMP_MAX) ? TEMP_MAX : low_q;
	assign limits.high = (high_q > TEMP_MAX) ? TEMP_MAX : high_q;

endmodule

[hdl/tthc_rom.sv]
// Divider reading to degrees Celsius lookup ROM, registered read.
module tthc_rom import tthc_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [ROM_AW-1:0] addr,
	output logic [TEMP_W-1:0] rdata
);

	localparam tthc_rom_t ROM_DATA = build_rom();

	logic [TEMP_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			rdata_q <= ROM_DATA[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hdl/thermistor_thermostat_controller.sv]
// Top level: on/off thermostat with set point control and averaged thermistor readings.
//
// cmd carries one item per event: opcode raise, lower or ADC sample, plus the
// 10-bit sample. disp returns exactly one item for every accepted cmd item: the
// heater state, set point and measured temperature with their decimal digits,
// and reading_done when a sample closed a group of SAMPLES_PER_READING.
// Limits are written over the APB port (low at 0x0, high at 0x4) while idle;
// the user must keep to this, the block does not enforce it. A cmd item passes
// the input register, stage 2 and the output register. Throughput: one item per
// cycle while disp does not stall; set point clamp, sample accumulate and reciprocal
// average run in stage 2 with the registered ROM read, the measured value update and
// digit split in stage 3. When disp stalls, the output register holds its item and
// up to two more items fill the input and ROM stages before cmd.ready drops.
// Reset (arst_n low) empties the pipeline, sets the set point to 50, the
// measured temperature and the sample group to 0, and the limits to 40 and 80.
module thermistor_thermostat_controller import tthc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	tthc_cmd_if.sink           cmd,
	tthc_disp_if.source        disp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	tthc_limits_t limits;

	tthc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.limits  (limits)
	);

	logic en1, en2, en3;

	// stage 1: input register
	logic                valid_s1;
	logic [OPCODE_W-1:0] opcode_s1;
	logic [SAMPLE_W-1:0] sample_s1;

	// state
	logic [TEMP_W-1:0]  set_point_q;
	logic [TEMP_W-1:0]  measured_q;
	logic [SUM_W-1:0]   sum_q;
	logic [COUNT_W-1:0] count_q;

	// stage 2
	logic              valid_s2;
	logic              done_s2;
	logic [TEMP_W-1:0] set_point_s2;
	logic [TEMP_W-1:0] rom_rdata;

	// output register
	logic               disp_valid_q;
	logic               heater_q;
	logic [TEMP_W-1:0]  set_point_out_q;
	tthc_digits_t       set_digits_q;
	logic [TEMP_W-1:0]  measured_out_q;
	tthc_digits_t       meas_digits_q;
	logic               done_out_q;

	assign en3       = !disp_valid_q || disp.ready;
	assign en2       = !valid_s2 || en3;
	assign en1       = !valid_s1 || en2;
	assign cmd.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en1) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && cmd.valid) begin
			opcode_s1 <= cmd.opcode;
			sample_s1 <= cmd.sample;
		end
	end

	// stage 2 datapath
	logic [TEMP_W-1:0]          sp_inc, sp_dec, sp_next;
	logic [SUM_W-1:0]           sum_add, sum_next;
	logic [COUNT_W-1:0]         count_add, count_next;
	logic                       done;
	logic [SUM_W+RECIP_W-1:0]   avg_prod;
	logic [ROM_AW-1:0]          avg;

	assign sp_inc    = set_point_q + 7'd1;
	assign sp_dec    = (set_point_q == '0) ? '0 : set_point_q - 7'd1;
	assign sum_add   = sum_q + SUM_W'(sample_s1);
	assign count_add = count_q + COUNT_W'(1);
	assign avg_prod  = (SUM_W+RECIP_W)'(sum_add) * (SUM_W+RECIP_W)'(RECIP);
	assign avg       = avg_prod[RECIP_SHIFT +: ROM_AW];

	always_comb begin
		sp_next    = set_point_q;
		sum_next   = sum_q;
		count_next = count_q;
		done       = 1'b0;
		unique case (tthc_op_t'(opcode_s1))
			OP_RAISE: sp_next = (sp_inc > limits.high) ? limits.high : sp_inc;
			OP_LOWER: sp_next = (sp_dec < limits.low) ? limits.low : sp_dec;
			OP_SAMPLE: begin
				if (count_add >= COUNT_W'(SAMPLES_PER_READING)) begin
					sum_next   = '0;
					count_next = '0;
					done       = 1'b1;
				end else begin
					sum_next   = sum_add;
					count_next = count_add;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_point_q <= SET_POINT_RESET;
			sum_q       <= '0;
			count_q     <= '0;
			valid_s2    <= 1'b0;
			done_s2     <= 1'b0;
		end else if (en2) begin
			valid_s2 <= valid_s1;
			done_s2  <= valid_s1 && done;
			if (valid_s1) begin
				set_point_q <= sp_next;
				sum_q       <= sum_next;
				count_q     <= count_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && valid_s1) begin
			set_point_s2 <= sp_next;
		end
	end

	tthc_rom u_rom (
		.clk   (clk),
		.en    (en2),
		.addr  (avg),
		.rdata (rom_rdata)
	);

	// stage 3: measured value update and output register
	logic [TEMP_W-1:0] meas_next;

	assign meas_next = done_s2 ? rom_rdata : measured_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			measured_q   <= '0;
			disp_valid_q <= 1'b0;
		end else if (en3) begin
			disp_valid_q <= valid_s2;
			if (valid_s2) begin
				measured_q <= meas_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && valid_s2) begin
			heater_q        <= meas_next < set_point_s2;
			set_point_out_q <= set_point_s2;
			set_digits_q    <= split_digits(set_point_s2);
			measured_out_q  <= meas_next;
			meas_digits_q   <= split_digits(meas_next);
			done_out_q      <= done_s2;
		end
	end

	assign disp.valid         = disp_valid_q;
	assign disp.heater_on     = heater_q;
	assign disp.set_point_now = set_point_out_q;
	assign disp.set_tens      = set_digits_q.tens;
	assign disp.set_ones      = set_digits_q.ones;
	assign disp.measured_now  = measured_out_q;
	assign disp.measured_tens = meas_digits_q.tens;
	assign disp.measured_ones = meas_digits_q.ones;
	assign disp.reading_done  = done_out_q;

	a_set_point_range: assert property (@(posedge clk) disable iff (!arst_n)
		set_point_q <= TEMP_MAX)
		else $error("set point left 0..99");

	a_measured_range: assert property (@(posedge clk) disable iff (!arst_n)
		measured_q <= TEMP_MAX)
		else $error("measured temperature left 0..99");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q < COUNT_W'(SAMPLES_PER_READING))
		else $error("sample count reached group size without closing");

	a_heater_rule: assert property (@(posedge clk) disable iff (!arst_n)
		disp.valid |-> disp.heater_on == (disp.measured_now < disp.set_point_now))
		else $error("heater state disagrees with shown values");

	a_measured_matches: assert property (@(posedge clk) disable iff (!arst_n)
		disp.valid |-> disp.measured_now == measured_q)
		else $error("shown measured value differs from stored state");

endmodule

[test/tb_top.sv]
// Self-checking testbench for the thermistor thermostat controller: directed and random items.
`timescale 1ns / 100ps

module tb_top;
	import tthc_pkg::*;

	typedef struct packed {
		logic               heater_on;
		logic [TEMP_W-1:0]  set_point_now;
		logic [DIGIT_W-1:0] set_tens;
		logic [DIGIT_W-1:0] set_ones;
		logic [TEMP_W-1:0]  measured_now;
		logic [DIGIT_W-1:0] measured_tens;
		logic [DIGIT_W-1:0] measured_ones;
		logic               reading_done;
	} disp_item_t;

	localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
	localparam logic [63:0] Q48_ONE = 64'd1 << 48;
	localparam int MAX_REPORTS = 10;
	localparam int PIPE_CYCLES = 3;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	tthc_cmd_if  cmd_if ();
	tthc_disp_if disp_if ();

	thermistor_thermostat_controller DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_if),
		.disp    (disp_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_left = 0;
	int error_count = 0;
	int items_sent = 0;

	// thermostat state as predicted
	logic [TEMP_W-1:0] lim_low;
	logic [TEMP_W-1:0] lim_high;
	logic [TEMP_W-1:0] set_pt;
	logic [TEMP_W-1:0] meas_temp;
	logic [SUM_W-1:0]  grp_sum;
	int                grp_cnt;

	logic [TEMP_W-1:0] deg_table [ROM_DEPTH];
	disp_item_t        expected_displays [$];

	// ---- divider reading to degrees, Q48 fixed point ----
	function automatic logic [63:0] mul_q(input logic [63:0] a, input logic [63:0] b,
		input int sh);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		p = p >> sh;
		return p[63:0];
	endfunction

	function automatic logic [63:0] q48_quot(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] rem;
		logic [63:0] q;
		rem = num;
		q = '0;
		repeat (48) begin
			rem = rem << 1;
			q = q << 1;
			if (rem >= den) begin
				rem = rem - den;
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	// 2*atanh(z), 21 odd terms
	function automatic logic [63:0] log_series(input logic [63:0] z);
		logic [63:0] z2;
		logic [63:0] term;
		logic [63:0] acc;
		z2 = mul_q(z, z, 48);
		term = z;
		acc = '0;
		for (int k = 1; k <= 41; k += 2) begin
			acc = acc + term / 64'(k);
			term = mul_q(term, z2, 48);
		end
		return acc << 1;
	endfunction

	function automatic logic [63:0] ln_fixed(input logic [63:0] r, input logic [63:0] ln2);
		int unsigned e;
		logic [63:0] m;
		e = 0;
		while (e < 40 && (r >> (e + 1)) != 0) e++;
		m = r << (48 - e);
		return 64'(e) * ln2 + log_series(q48_quot(m - Q48_ONE, m + Q48_ONE));
	endfunction

	function automatic logic [TEMP_W-1:0] table_entry(input int v, input logic [63:0] ln2);
		longint      r;
		logic [63:0] l;
		logic [63:0] l3;
		logic [63:0] nq;
		int          deg;
		if (v == 0) return '0;
		r = longint'(10230000 / v) - 10000;
		if (r <= 0) return TEMP_MAX;
		l = ln_fixed(64'(r), ln2);
		l3 = mul_q(mul_q(l, l, 48), l, 48);
		nq = (64'd11291480000 << 12) + mul_q(l, 64'd2341250000, 36)
			+ mul_q(l3, 64'd876741, 36);
		deg = 0;
		for (int k = 1; k <= 99; k++) begin
			if (nq * (64'd27315 + 64'd100 * 64'(k)) <= 64'd4096000000000000000) deg = k;
			else break;
		end
		return TEMP_W'(deg);
	endfunction

	function automatic void fill_table();
		logic [63:0] ln2;
		ln2 = log_series(Q48_ONE / 3);
		for (int v = 0; v < ROM_DEPTH; v++) deg_table[v] = table_entry(v, ln2);
	endfunction

	// ---- prediction ----
	function automatic disp_item_t next_display(input logic [OPCODE_W-1:0] op,
		input logic [SAMPLE_W-1:0] smp);
		disp_item_t        d;
		logic [TEMP_W-1:0] lo;
		logic [TEMP_W-1:0] hi;
		logic [TEMP_W-1:0] n;
		lo = lim_low > TEMP_MAX ? TEMP_MAX : lim_low;
		hi = lim_high > TEMP_MAX ? TEMP_MAX : lim_high;
		d.reading_done = 1'b0;
		case (op)
			OP_RAISE: begin
				n = set_pt + 7'd1;
				set_pt = n > hi ? hi : n;
			end
			OP_LOWER: begin
				n = set_pt == 0 ? 7'd0 : set_pt - 7'd1;
				set_pt = n < lo ? lo : n;
			end
			OP_SAMPLE: begin
				grp_sum = grp_sum + SUM_W'(smp);
				grp_cnt++;
				if (grp_cnt >= SAMPLES_PER_READING) begin
					meas_temp = deg_table[ROM_AW'(grp_sum / SAMPLES_PER_READING)];
					grp_sum = '0;
					grp_cnt = 0;
					d.reading_done = 1'b1;
				end
			end
			default: ;
		endcase
		d.heater_on = meas_temp < set_pt;
		d.set_point_now = set_pt;
		d.set_tens = DIGIT_W'(set_pt / 10);
		d.set_ones = DIGIT_W'(set_pt % 10);
		d.measured_now = meas_temp;
		d.measured_tens = DIGIT_W'(meas_temp / 10);
		d.measured_ones = DIGIT_W'(meas_temp % 10);
		return d;
	endfunction

	// ---- checking ----
	function automatic string item_text(input disp_item_t d);
		return $sformatf("heater=%0d sp=%0d (%0d %0d) meas=%0d (%0d %0d) done=%0d",
			d.heater_on, d.set_point_now, d.set_tens, d.set_ones, d.measured_now,
			d.measured_tens, d.measured_ones, d.reading_done);
	endfunction

	function automatic void note_error(input string msg);
		error_count++;
		if (error_count <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, msg);
	endfunction

	task automatic check_display();
		disp_item_t got;
		disp_item_t want;
		string      bad;
		got.heater_on = disp_if.heater_on;
		got.set_point_now = disp_if.set_point_now;
		got.set_tens = disp_if.set_tens;
		got.set_ones = disp_if.set_ones;
		got.measured_now = disp_if.measured_now;
		got.measured_tens = disp_if.measured_tens;
		got.measured_ones = disp_if.measured_ones;
		got.reading_done = disp_if.reading_done;
		if (expected_displays.size() == 0) begin
			note_error({"unexpected item: ", item_text(got)});
			return;
		end
		want = expected_displays.pop_front();
		bad = "";
		if (got.heater_on !== want.heater_on) bad = {bad, " heater_on"};
		if (got.set_point_now !== want.set_point_now) bad = {bad, " set_point_now"};
		if (got.set_tens !== want.set_tens) bad = {bad, " set_tens"};
		if (got.set_ones !== want.set_ones) bad = {bad, " set_ones"};
		if (got.measured_now !== want.measured_now) bad = {bad, " measured_now"};
		if (got.measured_tens !== want.measured_tens) bad = {bad, " measured_tens"};
		if (got.measured_ones !== want.measured_ones) bad = {bad, " measured_ones"};
		if (got.reading_done !== want.reading_done) bad = {bad, " reading_done"};
		if (bad != "")
			note_error({"mismatch in", bad, ": expected ", item_text(want),
				", got ", item_text(got)});
	endtask

	// display receiver
	initial begin
		disp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				disp_if.ready <= 1'b0;
				hold_left--;
			end else begin
				disp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
			@(posedge clk);
			if (disp_if.valid === 1'b1 && disp_if.ready === 1'b1) check_display();
		end
	end

	// ---- drivers ----
	task automatic send_cmd(input logic [OPCODE_W-1:0] op, input logic [SAMPLE_W-1:0] smp);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_if.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_if.valid <= 1'b1;
		cmd_if.opcode <= op;
		cmd_if.sample <= smp;
		do @(posedge clk); while (cmd_if.ready !== 1'b1);
		expected_displays.push_back(next_display(op, smp));
		items_sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		cmd_if.valid <= 1'b0;
		while (expected_displays.size() != 0) @(posedge clk);
		repeat (PIPE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input tthc_reg_t idx, input logic [TEMP_W-1:0] val);
		logic [PDATA_W-1:0] word;
		word = {(PDATA_W-TEMP_W)'($urandom), val};
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'({idx, 2'b00});
		pwdata <= word;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		case (idx)
			REG_LOW:  lim_low = word[TEMP_W-1:0];
			REG_HIGH: lim_high = word[TEMP_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_limits(input logic [TEMP_W-1:0] lo, input logic [TEMP_W-1:0] hi);
		wait_drained();
		write_reg(REG_LOW, lo);
		write_reg(REG_HIGH, hi);
	endtask

	task automatic change_limits();
		logic [TEMP_W-1:0] lo;
		case ($urandom_range(5))
			0: set_limits(7'd0, 7'd99);
			1: set_limits(7'd99, 7'd0);
			2: set_limits(7'd127, 7'd127);
			3: set_limits(7'd0, 7'd127);
			4: begin
				lo = TEMP_W'($urandom_range(60));
				set_limits(lo, TEMP_W'($urandom_range(lo + 5, 127)));
			end
			default: set_limits(TEMP_W'($urandom_range(127)), TEMP_W'($urandom_range(127)));
		endcase
	endtask

	// ---- random sequences ----
	task automatic send_sample_group();
		int                  mode;
		int                  center;
		logic [SAMPLE_W-1:0] smp;
		mode = $urandom_range(9);
		center = $urandom_range(150, 1023);
		for (int i = 0; i < SAMPLES_PER_READING; i++) begin
			// noise inside the group
			if ($urandom_range(19) == 0) send_cmd(OPCODE_W'($urandom_range(3)), SAMPLE_W'($urandom));
			case (mode)
				0, 1: smp = SAMPLE_W'($urandom);
				7: smp = ($urandom_range(12) == 0) ? 10'd1 : 10'd0;
				8: smp = ($urandom_range(3) == 0) ? 10'h3FE : 10'h3FF;
				9: smp = SAMPLE_W'($urandom_range(200));
				default: begin
					center = center + $urandom_range(0, 32) - 16;
					if (center < 0) center = 0;
					if (center > 1023) center = 1023;
					smp = SAMPLE_W'(center);
				end
			endcase
			send_cmd(OP_SAMPLE, smp);
		end
	endtask

	task automatic send_set_point_burst();
		int                  n;
		logic [OPCODE_W-1:0] op;
		n = $urandom_range(1, 40);
		op = $urandom_range(1) ? OP_RAISE : OP_LOWER;
		repeat (n) begin
			if ($urandom_range(7) == 0) send_cmd(OPCODE_W'($urandom_range(3)), SAMPLE_W'($urandom));
			else send_cmd(op, SAMPLE_W'($urandom));
		end
	endtask

	task automatic run_random_phase(input int s_pct, input int r_pct, input int n_items);
		int start;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		repeat (3) begin
			change_limits();
			start = items_sent;
			while (items_sent - start < n_items / 3) begin
				if ($urandom_range(3) == 0) send_set_point_burst();
				else send_sample_group();
			end
		end
	endtask

	// ---- tests ----
	task automatic test_set_point_limits();
		send_cmd(OP_UNUSED, 10'h3FF);
		set_limits(7'd120, 7'd0);
		send_cmd(OP_LOWER, 10'h000);
		send_cmd(OP_RAISE, 10'h3FF);
		set_limits(7'd0, 7'd127);
		send_cmd(OP_LOWER, 10'h155);
		send_cmd(OP_RAISE, 10'h2AA);
		set_limits(7'd99, 7'd127);
		send_cmd(OP_LOWER, 10'h000);
		send_cmd(OP_RAISE, 10'h000);
		set_limits(7'd48, 7'd52);
		repeat (2) send_cmd(OP_RAISE, 10'h000);
		repeat (5) send_cmd(OP_LOWER, 10'h000);
	endtask

	task automatic test_hot_reading();
		for (int i = 0; i < SAMPLES_PER_READING; i++) begin
			if (i == 6) send_cmd(OP_UNUSED, 10'h000);
			send_cmd(OP_SAMPLE, 10'h3FF);
		end
	endtask

	task automatic test_backpressure();
		int saved;
		wait_drained();
		saved = send_idle_pct;
		send_idle_pct = 0;
		hold_left = 60;
		repeat (2) send_sample_group();
		send_idle_pct = saved;
		wait_drained();
	endtask

	task automatic finish_run();
		wait_drained();
		repeat (8) @(posedge clk);
		if (error_count == 0 && expected_displays.size() == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	endtask

	initial begin
		arst_n = 1'b0;
		cmd_if.valid = 1'b0;
		cmd_if.opcode = '0;
		cmd_if.sample = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		lim_low = LOW_RESET;
		lim_high = HIGH_RESET;
		set_pt = SET_POINT_RESET;
		meas_temp = '0;
		grp_sum = '0;
		grp_cnt = 0;
		fill_table();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 26;
		recv_idle_pct = 46;
		test_set_point_limits();
		test_hot_reading();
		test_backpressure();
		run_random_phase(26, 46, 700);
		run_random_phase(46, 26, 700);
		run_random_phase(0, 0, 600);
		finish_run();
	end

	initial begin
		#2000000;
		$display("tb_top: done, errors");
		$finish;
	end

endmodule

[files.f]
hdl/tthc_pkg.sv
hdl/tthc_ifs.sv
hdl/tthc_regs.sv
hdl/tthc_rom.sv
hdl/thermistor_thermostat_controller.sv
test/tb_top.sv
